FILE: rtl/seven_bit_group_packer_unit_macros.svh
// Assertion macros of the seven-bit group packer, used by the group queue.
`ifndef SEVEN_BIT_GROUP_PACKER_UNIT_MACROS_SVH
`define SEVEN_BIT_GROUP_PACKER_UNIT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define SBGP_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define SBGP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sbgp_pkg.sv
// Shared constants and word types of the seven-bit group packer.
package sbgp_pkg;

    // Group geometry.
    localparam int GROUP_SIZE = 7;
    localparam int LOW_W      = 7;
    localparam int CNT_W      = 3;

    // Group queue between the packer front and the serializer back.
    // The depth must be a power of two so that the pointers wrap naturally.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Input operation codes.
    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Input word.
    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic [LOW_W-1:0] out_byte;
        logic             last;
    } t_out_word;

    // One complete group: aligned header, held bytes, and byte count (1 to 7).
    typedef struct packed {
        logic [LOW_W-1:0]                  header;
        logic [GROUP_SIZE-1:0][LOW_W-1:0]  bytes;
        logic [CNT_W-1:0]                  count;
    } t_group;

endpackage

FILE: rtl/sbgp_front.sv
// Front end: accepts words, collects low bits and top bits, and closes groups.
module sbgp_front import sbgp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_word i_word,
    output logic     o_grp_valid,
    output t_group   o_grp
);

    logic [LOW_W-1:0] r_held [0:GROUP_SIZE-2];
    logic [LOW_W-1:0] r_top;
    logic [CNT_W-1:0] r_count;
    logic [LOW_W-1:0] n_top;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] shamt;
    logic             is_data;
    logic             close_full;
    logic             close_flush;

    assign is_data     = i_valid && (i_word.opcode == OP_DATA);
    assign close_full  = is_data && (r_count == CNT_W'(GROUP_SIZE - 1));
    assign close_flush = i_valid && (i_word.opcode == OP_FLUSH) && (r_count != '0);
    assign shamt       = CNT_W'(GROUP_SIZE) - r_count;

    // Top bits shift in from the right as data words arrive.
    assign n_top = {r_top[LOW_W-2:0], i_word.data_byte[7]};

    // Build the outgoing group; the seventh byte comes straight from the input.
    always_comb begin
        o_grp_valid = close_full || close_flush;
        for (int k = 0; k < GROUP_SIZE - 1; k++) begin
            o_grp.bytes[k] = r_held[k];
        end
        o_grp.bytes[GROUP_SIZE-1] = i_word.data_byte[LOW_W-1:0];
        if (close_full) begin
            o_grp.header = n_top;
            o_grp.count  = CNT_W'(GROUP_SIZE);
        end else begin
            o_grp.header = r_top << shamt;
            o_grp.count  = r_count;
        end
    end

    // Next held count.
    always_comb begin
        n_count = r_count;
        if (close_full || close_flush) begin
            n_count = '0;
        end else if (is_data) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_top   <= '0;
        end else begin
            r_count <= n_count;
            if (close_full || close_flush) begin
                r_top <= '0;
            end else if (is_data) begin
                r_top <= n_top;
            end
        end
    end

    // Held bytes need no reset; only entries below the count are ever read.
    always_ff @(posedge i_clk) begin
        if (is_data && !close_full) begin
            r_held[r_count] <= i_word.data_byte[LOW_W-1:0];
        end
    end

endmodule

FILE: rtl/sbgp_queue.sv
// Short queue of complete groups between the front end and the serializer.
`include "seven_bit_group_packer_unit_macros.svh"

module sbgp_queue import sbgp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_enq,
    input  t_group i_grp,
    output logic   o_full,
    input  logic   i_deq,
    output logic   o_empty,
    output t_group o_grp
);

    t_group              r_mem [0:QDEPTH-1];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_grp   = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_enq) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_deq) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_enq && !i_deq) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (i_deq && !i_enq) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    // Group storage.
    always_ff @(posedge i_clk) begin
        if (i_enq) begin
            r_mem[r_wr_ptr] <= i_grp;
        end
    end

    // The front end must never close a group into a full queue.
    `SBGP_ASSERT_ALWAYS(a_no_enq_full, i_clk, i_rst_n, !(i_enq && o_full), "push while full")
    // The serializer must never take a group that is not there.
    `SBGP_ASSERT_ALWAYS(a_no_deq_empty, i_clk, i_rst_n, !(i_deq && o_empty), "pop while empty")
    // A lone push raises the fill count by one.
    `SBGP_ASSERT_NEXT(a_cnt_up, i_clk, i_rst_n, i_enq && !i_deq, r_cnt == $past(r_cnt) + 2'd1, "no rise")

endmodule

FILE: rtl/sbgp_back.sv
// Back end: serializes one group per pass into the result output register.
module sbgp_back import sbgp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_grp_empty,
    input  t_group    i_grp,
    output logic      o_grp_deq,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_word o_word
);

    logic              r_valid;
    t_out_word         r_word;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  byte_sel;
    logic              load;
    logic              cur_last;
    t_out_word         n_word;

    // A new word enters when a group is waiting and the output register is free or is being taken.
    assign load     = !i_grp_empty && (!r_valid || i_pop);
    assign byte_sel = r_idx - CNT_W'(1);
    assign cur_last = (r_idx != '0) && (r_idx == i_grp.count);

    // Header at index zero, then the held bytes in arrival order.
    always_comb begin
        if (r_idx == '0) begin
            n_word.out_byte = i_grp.header;
        end else begin
            n_word.out_byte = i_grp.bytes[byte_sel];
        end
        n_word.last = cur_last;
    end

    assign o_grp_deq = load && cur_last;
    assign o_empty   = !r_valid;
    assign o_word    = r_word;

    // Index within the current group and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= cur_last ? '0 : r_idx + CNT_W'(1);
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= n_word;
        end
    end

endmodule

FILE: rtl/seven_bit_group_packer_unit.sv
// Top level of the seven-bit group packer: front end, group queue, serializer.
//
//   Channel  | Handshake        | Word             | Fields
//   ---------+------------------+------------------+--------------------------
//   input    | push / full      | i_in_word        | opcode, data_byte
//   result   | pop / empty      | o_out_word       | out_byte, last
//
// An input word is taken whenever the group queue (two groups) has room.
// A closed group is written into the group queue, and its header is then loaded into the
// output register for the result port once that register is free.
// The serializer sends one result word per cycle while results are popped and groups wait;
// a full group of seven data words gives eight result words, header first.
// Reset clears the held count, top bits, queue pointers and output valid; held bytes
// need no clearing. Either side may stall at any time without losing words.
module seven_bit_group_packer_unit import sbgp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_word  i_in_word,
    output logic      empty,
    input  logic      pop,
    output t_out_word o_out_word
);

    logic   accept;
    logic   grp_valid;
    t_group grp_in;
    t_group grp_out;
    logic   q_full;
    logic   q_empty;
    logic   q_deq;
    logic   res_empty;

    assign full   = q_full;
    assign empty  = res_empty;
    assign accept = push && !q_full;

    // Word collection and group closing.
    sbgp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_word      (i_in_word),
        .o_grp_valid (grp_valid),
        .o_grp       (grp_in)
    );

    // Closed groups waiting for the serializer.
    sbgp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_enq   (grp_valid),
        .i_grp   (grp_in),
        .o_full  (q_full),
        .i_deq   (q_deq),
        .o_empty (q_empty),
        .o_grp   (grp_out)
    );

    // One result word per cycle while results are popped and groups wait.
    sbgp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp_empty (q_empty),
        .i_grp       (grp_out),
        .o_grp_deq   (q_deq),
        .o_empty     (res_empty),
        .i_pop       (pop && !res_empty),
        .o_word      (o_out_word)
    );

endmodule
